// File: design/frb_pkg.sv
// Shared constants, codes and helpers for the framed bitmap receiver.
`default_nettype none
package frb_pkg;

    localparam int LENGTH_BITS_DEF = 20;

    localparam int WIDTH_W  = 16;
    localparam int HEIGHT_W = 16;
    localparam int LEN_W    = 20;
    localparam int LIMIT_W  = 8;
    localparam int ADDR_W   = 20;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 20;
    localparam int EVENT_W  = 3;
    localparam int OUT_DATA_W = 40;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

    localparam logic [7:0] MAGIC_0 = 8'hDE;
    localparam logic [7:0] MAGIC_1 = 8'hAD;
    localparam logic [7:0] MAGIC_2 = 8'hBE;
    localparam logic [7:0] MAGIC_3 = 8'hEF;

    localparam logic [7:0] REPLY_ACK  = 8'h06;
    localparam logic [7:0] REPLY_NAK  = 8'h15;
    localparam logic [7:0] REPLY_BTN  = 8'h42;
    localparam logic [7:0] REPLY_NONE = 8'h00;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 8'd3;

    localparam logic [WIDTH_W-1:0]  RST_WIDTH  = 16'd648;
    localparam logic [HEIGHT_W-1:0] RST_HEIGHT = 16'd480;
    localparam logic [LEN_W-1:0]    RST_LENGTH = 20'd38880;
    localparam logic [LIMIT_W-1:0]  RST_LIMIT  = 8'd10;

    typedef enum logic [EVENT_W-1:0] {
        EV_PAYLOAD  = 3'd0,
        EV_ACCEPT   = 3'd1,
        EV_HDR_REJ  = 3'd2,
        EV_CRC_REJ  = 3'd3,
        EV_PG_TAKEN = 3'd4,
        EV_PG_REFUSED = 3'd5
    } t_event;

    typedef enum logic [3:0] {
        PH_HUNT    = 4'b0001,
        PH_HEADER  = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_TRAILER = 4'b1000
    } t_phase;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] m;
        case (idx)
            2'd0: m = MAGIC_0;
            2'd1: m = MAGIC_1;
            2'd2: m = MAGIC_2;
            default: m = MAGIC_3;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

// File: design/frb_crc_byte.sv
// Byte-wide reflected CRC-32 update.
`default_nettype none
module frb_crc_byte (
    input  wire logic [31:0] i_crc,
    input  wire logic [7:0]  i_byte,
    output logic      [31:0] o_crc
);

    always_comb begin
        logic [31:0] c;
        c = i_crc ^ {24'd0, i_byte};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (c[0] ? frb_pkg::CRC_POLY : 32'd0);
        end
        o_crc = c;
    end

endmodule
`default_nettype wire

// File: design/framed_bitmap_receiver_crc32.sv
// Framed bitmap receiver: magic hunt, header check, payload forward, CRC-32 check.
//
// Input stream (s_axis): tdata carries one serial byte, tuser marks a page
// change request (1) instead of a byte (0). Output stream (m_axis): tuser is
// the event code, tdata packs payload byte, byte address, full refresh flag
// and reply byte. Config channel writes expected width, height, length and
// partial limit by index; writes beyond the list are dropped.
// Each item is decoded in the cycle it is accepted and its result, if any,
// lands in the output register. One item per cycle is taken while the output
// register is empty or drained. The byte-wide CRC update and the header compare
// sit in that decode. Hunting bytes, header bytes but a rejecting last one,
// and early trailer bytes give no result. The input is taken whenever the
// output register is empty or being drained in the same cycle, so a stalled
// receiver holds the result and stops input only once the output register is
// full. Reset returns to hunting with all counters and flags cleared and the
// registers at their defaults.
`default_nettype none
module framed_bitmap_receiver_crc32 #(
    parameter int LENGTH_BITS = frb_pkg::LENGTH_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  wire logic        i_s_axis_tuser,   // [0] kind
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [frb_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    // [7:0] payload_byte, [27:8] byte_address, [28] full_refresh,
    // [36:29] reply_byte, [39:37] zero
    output logic [frb_pkg::EVENT_W-1:0]    o_m_axis_tuser, // [2:0] event_res
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [frb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [frb_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic [frb_pkg::WIDTH_W-1:0]  r_exp_width;
    logic [frb_pkg::HEIGHT_W-1:0] r_exp_height;
    logic [frb_pkg::LEN_W-1:0]    r_exp_len;
    logic [frb_pkg::LIMIT_W-1:0]  r_part_limit;

    frb_pkg::t_phase r_phase, n_phase;
    logic [1:0]  r_magic, n_magic;
    logic [2:0]  r_hdr_cnt, n_hdr_cnt;
    logic [63:0] r_hdr, n_hdr;
    logic [LENGTH_BITS-1:0] r_pay_cnt, n_pay_cnt;
    logic [31:0] r_crc, n_crc;
    logic [1:0]  r_trl_cnt, n_trl_cnt;
    logic [31:0] r_trl, n_trl;
    logic [frb_pkg::LIMIT_W-1:0] r_part_cnt, n_part_cnt;
    logic        r_pg_flag, n_pg_flag;

    logic        r_out_valid;
    frb_pkg::t_event r_out_ev, n_out_ev;
    logic [7:0]  r_out_pb, n_out_pb;
    logic [frb_pkg::ADDR_W-1:0] r_out_addr, n_out_addr;
    logic        r_out_full, n_out_full;
    logic [7:0]  r_out_reply, n_out_reply;
    logic        n_has;

    logic        s_acc;
    logic [LENGTH_BITS-1:0] limit;
    logic [31:0] crc_next;
    logic [LENGTH_BITS-1:0] pay_inc;
    logic [31:0] hdr_len;
    logic [31:0] trl_full;
    logic        want_full;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign limit           = LENGTH_BITS'(r_exp_len);
    assign pay_inc         = r_pay_cnt + 1'b1;
    assign hdr_len         = {i_s_axis_tdata, r_hdr[55:32]};
    assign trl_full        = {i_s_axis_tdata, r_trl[23:0]};
    assign want_full       = r_pg_flag || (r_part_cnt >= r_part_limit);

    frb_crc_byte u_crc (
        .i_crc  (r_crc),
        .i_byte (i_s_axis_tdata),
        .o_crc  (crc_next)
    );

    always_comb begin
        n_phase     = r_phase;
        n_magic     = r_magic;
        n_hdr_cnt   = r_hdr_cnt;
        n_hdr       = r_hdr;
        n_pay_cnt   = r_pay_cnt;
        n_crc       = r_crc;
        n_trl_cnt   = r_trl_cnt;
        n_trl       = r_trl;
        n_part_cnt  = r_part_cnt;
        n_pg_flag   = r_pg_flag;
        n_has       = 1'b0;
        n_out_ev    = frb_pkg::EV_PAYLOAD;
        n_out_pb    = 8'd0;
        n_out_addr  = '0;
        n_out_full  = 1'b0;
        n_out_reply = frb_pkg::REPLY_NONE;
        if (s_acc) begin
            if (i_s_axis_tuser) begin
                n_has = 1'b1;
                if (r_phase == frb_pkg::PH_HUNT) begin
                    n_pg_flag   = 1'b1;
                    n_out_ev    = frb_pkg::EV_PG_TAKEN;
                    n_out_reply = frb_pkg::REPLY_BTN;
                end else begin
                    n_out_ev = frb_pkg::EV_PG_REFUSED;
                end
            end else begin
                case (r_phase)
                    frb_pkg::PH_HUNT: begin
                        if (i_s_axis_tdata == frb_pkg::magic_byte(r_magic)) begin
                            n_magic = r_magic + 2'd1;
                            if (r_magic == 2'd3) begin
                                n_hdr_cnt = 3'd0;
                                n_hdr     = '0;
                                n_phase   = frb_pkg::PH_HEADER;
                            end
                        end else begin
                            n_magic = (i_s_axis_tdata == frb_pkg::MAGIC_0) ? 2'd1 : 2'd0;
                        end
                    end
                    frb_pkg::PH_HEADER: begin
                        n_hdr[{r_hdr_cnt, 3'b000} +: 8] = i_s_axis_tdata;
                        n_hdr_cnt = r_hdr_cnt + 3'd1;
                        if (r_hdr_cnt == 3'd7) begin
                            if (r_hdr[15:0] != r_exp_width
                                || r_hdr[31:16] != r_exp_height
                                || hdr_len != {12'd0, r_exp_len}) begin
                                n_phase     = frb_pkg::PH_HUNT;
                                n_magic     = 2'd0;
                                n_has       = 1'b1;
                                n_out_ev    = frb_pkg::EV_HDR_REJ;
                                n_out_reply = frb_pkg::REPLY_NAK;
                            end else begin
                                n_pay_cnt = '0;
                                n_crc     = frb_pkg::CRC_ONES;
                                n_trl_cnt = 2'd0;
                                n_trl     = '0;
                                n_phase   = (limit == '0) ? frb_pkg::PH_TRAILER
                                                          : frb_pkg::PH_PAYLOAD;
                            end
                        end
                    end
                    frb_pkg::PH_PAYLOAD: begin
                        n_crc     = crc_next;
                        n_pay_cnt = pay_inc;
                        if (pay_inc >= limit || pay_inc == '0) begin
                            n_trl_cnt = 2'd0;
                            n_trl     = '0;
                            n_phase   = frb_pkg::PH_TRAILER;
                        end
                        n_has      = 1'b1;
                        n_out_ev   = frb_pkg::EV_PAYLOAD;
                        n_out_pb   = i_s_axis_tdata;
                        n_out_addr = frb_pkg::ADDR_W'(r_pay_cnt);
                    end
                    frb_pkg::PH_TRAILER: begin
                        n_trl[{r_trl_cnt, 3'b000} +: 8] = i_s_axis_tdata;
                        n_trl_cnt = r_trl_cnt + 2'd1;
                        if (r_trl_cnt == 2'd3) begin
                            n_phase = frb_pkg::PH_HUNT;
                            n_magic = 2'd0;
                            n_has   = 1'b1;
                            if (~r_crc == trl_full) begin
                                n_pg_flag   = 1'b0;
                                n_part_cnt  = want_full ? '0 : r_part_cnt + 1'b1;
                                n_out_ev    = frb_pkg::EV_ACCEPT;
                                n_out_full  = want_full;
                                n_out_reply = frb_pkg::REPLY_ACK;
                            end else begin
                                n_out_ev    = frb_pkg::EV_CRC_REJ;
                                n_out_reply = frb_pkg::REPLY_NAK;
                            end
                        end
                    end
                    default: begin
                        n_phase = frb_pkg::PH_HUNT;
                        n_magic = 2'd0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_width  <= frb_pkg::RST_WIDTH;
            r_exp_height <= frb_pkg::RST_HEIGHT;
            r_exp_len    <= frb_pkg::RST_LENGTH;
            r_part_limit <= frb_pkg::RST_LIMIT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                frb_pkg::REG_WIDTH:  r_exp_width  <= i_cfg_data[frb_pkg::WIDTH_W-1:0];
                frb_pkg::REG_HEIGHT: r_exp_height <= i_cfg_data[frb_pkg::HEIGHT_W-1:0];
                frb_pkg::REG_LENGTH: r_exp_len    <= i_cfg_data[frb_pkg::LEN_W-1:0];
                frb_pkg::REG_LIMIT:  r_part_limit <= i_cfg_data[frb_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= frb_pkg::PH_HUNT;
            r_magic     <= 2'd0;
            r_hdr_cnt   <= 3'd0;
            r_pay_cnt   <= '0;
            r_trl_cnt   <= 2'd0;
            r_part_cnt  <= '0;
            r_pg_flag   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_magic    <= n_magic;
            r_hdr_cnt  <= n_hdr_cnt;
            r_pay_cnt  <= n_pay_cnt;
            r_trl_cnt  <= n_trl_cnt;
            r_part_cnt <= n_part_cnt;
            r_pg_flag  <= n_pg_flag;
            if (o_s_axis_tready) begin
                r_out_valid <= n_has;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr <= n_hdr;
        r_crc <= n_crc;
        r_trl <= n_trl;
        if (o_s_axis_tready && n_has) begin
            r_out_ev    <= n_out_ev;
            r_out_pb    <= n_out_pb;
            r_out_addr  <= n_out_addr;
            r_out_full  <= n_out_full;
            r_out_reply <= n_out_reply;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_ev;
    assign o_m_axis_tdata  = {3'd0, r_out_reply, r_out_full, r_out_addr, r_out_pb};

`ifndef NO_ASSERTIONS
    a_pg_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && i_s_axis_tuser) |=> (o_m_axis_tvalid
            && (r_out_ev == frb_pkg::EV_PG_TAKEN || r_out_ev == frb_pkg::EV_PG_REFUSED)))
        else $error("page change item gave no page change result");

    a_full_only_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_ev != frb_pkg::EV_ACCEPT) |-> !r_out_full)
        else $error("full refresh flagged outside an accept");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_m_axis_tready && !i_s_axis_tvalid) |=> !r_out_valid)
        else $error("output item repeated after being taken");

    a_reject_hunts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && n_has && (n_out_ev == frb_pkg::EV_HDR_REJ
            || n_out_ev == frb_pkg::EV_CRC_REJ || n_out_ev == frb_pkg::EV_ACCEPT))
        |=> (r_phase == frb_pkg::PH_HUNT && r_magic == 2'd0))
        else $error("frame end did not return to hunting");
`endif

endmodule
`default_nettype wire

// File: verif/frb_stream_checker.sv
// CRC-32 helper package and the stream checker that predicts and compares receiver results.
package frb_tb_pkg;

    function automatic logic [31:0] crc32_fold(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ frb_pkg::CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage

module frb_stream_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_tvalid,
    input  wire logic                            i_s_tready,
    input  wire logic [7:0]                      i_s_tdata,
    input  wire logic                            i_s_tuser,
    input  wire logic                            i_m_tvalid,
    input  wire logic                            i_m_tready,
    input  wire logic [frb_pkg::OUT_DATA_W-1:0]  i_m_tdata,
    input  wire logic [frb_pkg::EVENT_W-1:0]     i_m_tuser,
    input  wire logic                            i_cfg_valid,
    input  wire logic                            i_cfg_ready,
    input  wire logic [frb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [frb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                                   o_fail_count,
    output int                                   o_pending
);
    import frb_pkg::*;
    import frb_tb_pkg::*;

    typedef struct packed {
        logic [EVENT_W-1:0] ev;
        logic [7:0]         pixel;
        logic [ADDR_W-1:0]  addr;
        logic               full;
        logic [7:0]         reply;
    } frame_result_t;

    localparam logic [31:0] MAGIC_SEQ = {MAGIC_3, MAGIC_2, MAGIC_1, MAGIC_0};

    frame_result_t results_due[$];

    logic [WIDTH_W-1:0]  want_width;
    logic [HEIGHT_W-1:0] want_height;
    logic [LEN_W-1:0]    want_length;
    logic [LIMIT_W-1:0]  partial_cap;

    t_phase              rx_phase;
    logic [1:0]          magic_idx;
    logic [2:0]          hdr_cnt;
    logic [63:0]         hdr_bytes;
    logic [LEN_W-1:0]    pay_cnt;
    logic [31:0]         run_crc;
    logic [1:0]          trl_cnt;
    logic [31:0]         trl_bytes;
    logic [7:0]          partials_run;
    logic                page_pending;

    // advances the receiver state by one item; returns 1 when the item yields a result
    function automatic bit take_item(input logic kind, input logic [7:0] b,
                                     output frame_result_t r);
        logic full;
        r = '0;
        if (kind) begin
            if (rx_phase == PH_HUNT) begin
                page_pending = 1'b1;
                r.ev = EV_PG_TAKEN;
                r.reply = REPLY_BTN;
            end else begin
                r.ev = EV_PG_REFUSED;
            end
            return 1'b1;
        end
        case (rx_phase)
            PH_HUNT: begin
                if (b == MAGIC_SEQ[8*magic_idx +: 8]) begin
                    magic_idx = magic_idx + 2'd1;
                    if (magic_idx == 2'd0) begin
                        hdr_cnt = 3'd0;
                        hdr_bytes = 64'd0;
                        rx_phase = PH_HEADER;
                    end
                end else begin
                    magic_idx = (b == MAGIC_0) ? 2'd1 : 2'd0;
                end
                return 1'b0;
            end
            PH_HEADER: begin
                hdr_bytes = hdr_bytes | ({56'd0, b} << (8 * hdr_cnt));
                hdr_cnt = hdr_cnt + 3'd1;
                if (hdr_cnt != 3'd0)
                    return 1'b0;
                if (hdr_bytes[15:0] != want_width || hdr_bytes[31:16] != want_height ||
                    hdr_bytes[63:32] != {12'd0, want_length}) begin
                    rx_phase = PH_HUNT;
                    magic_idx = 2'd0;
                    r.ev = EV_HDR_REJ;
                    r.reply = REPLY_NAK;
                    return 1'b1;
                end
                pay_cnt = '0;
                run_crc = CRC_ONES;
                trl_cnt = 2'd0;
                trl_bytes = 32'd0;
                if (want_length == '0)
                    rx_phase = PH_TRAILER;
                else
                    rx_phase = PH_PAYLOAD;
                return 1'b0;
            end
            PH_PAYLOAD: begin
                r.ev = EV_PAYLOAD;
                r.pixel = b;
                r.addr = pay_cnt;
                run_crc = crc32_fold(run_crc, b);
                pay_cnt = pay_cnt + 1'b1;
                if (pay_cnt >= want_length || pay_cnt == '0) begin
                    trl_cnt = 2'd0;
                    trl_bytes = 32'd0;
                    rx_phase = PH_TRAILER;
                end
                return 1'b1;
            end
            default: begin
                trl_bytes = trl_bytes | ({24'd0, b} << (8 * trl_cnt));
                trl_cnt = trl_cnt + 2'd1;
                if (trl_cnt != 2'd0)
                    return 1'b0;
                rx_phase = PH_HUNT;
                magic_idx = 2'd0;
                if ((run_crc ^ CRC_ONES) == trl_bytes) begin
                    full = page_pending || (partials_run >= partial_cap);
                    page_pending = 1'b0;
                    partials_run = full ? 8'd0 : partials_run + 8'd1;
                    r.ev = EV_ACCEPT;
                    r.full = full;
                    r.reply = REPLY_ACK;
                end else begin
                    r.ev = EV_CRC_REJ;
                    r.reply = REPLY_NAK;
                end
                return 1'b1;
            end
        endcase
    endfunction

    always @(posedge i_clk) begin : watch
        frame_result_t got;
        frame_result_t want;
        frame_result_t predicted;
        if (!i_rst_n) begin
            want_width = RST_WIDTH;
            want_height = RST_HEIGHT;
            want_length = RST_LENGTH;
            partial_cap = RST_LIMIT;
            rx_phase = PH_HUNT;
            magic_idx = 2'd0;
            hdr_cnt = 3'd0;
            hdr_bytes = 64'd0;
            pay_cnt = '0;
            run_crc = CRC_ONES;
            trl_cnt = 2'd0;
            trl_bytes = 32'd0;
            partials_run = 8'd0;
            page_pending = 1'b0;
            results_due.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.ev = i_m_tuser;
                got.pixel = i_m_tdata[7:0];
                got.addr = i_m_tdata[27:8];
                got.full = i_m_tdata[28];
                got.reply = i_m_tdata[36:29];
                if (results_due.size() == 0) begin
                    o_fail_count = o_fail_count + 1;
                    $display("%0t: unexpected result ev %0d byte %02h addr %0d full %0b reply %02h",
                             $time, got.ev, got.pixel, got.addr, got.full, got.reply);
                end else begin
                    want = results_due.pop_front();
                    if (got != want) begin
                        o_fail_count = o_fail_count + 1;
                        // fields: ev/byte/addr/full/reply
                        $display(
                            "%0t: expected %0d/%02h/%0d/%0b/%02h got %0d/%02h/%0d/%0b/%02h",
                            $time, want.ev, want.pixel, want.addr, want.full, want.reply,
                            got.ev, got.pixel, got.addr, got.full, got.reply);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_WIDTH:  want_width = i_cfg_data[WIDTH_W-1:0];
                    REG_HEIGHT: want_height = i_cfg_data[HEIGHT_W-1:0];
                    REG_LENGTH: want_length = i_cfg_data[LEN_W-1:0];
                    REG_LIMIT:  partial_cap = i_cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                if (take_item(i_s_tuser, i_s_tdata, predicted))
                    results_due.push_back(predicted);
            end
        end
        o_pending = results_due.size();
    end

endmodule

// File: verif/framed_bitmap_receiver_crc32_tb.sv
// Testbench top: drives framed byte streams, page changes and register writes into the receiver.
module framed_bitmap_receiver_crc32_tb;
    import frb_pkg::*;
    import frb_tb_pkg::*;

    localparam int ITEM_TARGET = 1550;
    localparam int QUIET_TAIL  = 200;
    localparam int LONG_HOLD   = 300;
    localparam int STALL_LIMIT = 3000;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_PAGE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LAST  = 8'hFF;

    typedef enum int {FRAME_GOOD, FRAME_BAD_HEADER, FRAME_BAD_CRC} frame_fault_e;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [EVENT_W-1:0]    m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int items_sent;
    int hold_req;
    int hold_done;
    int frame_pos;
    int refuse_at;
    int idle_cycles = 0;
    bit gaps_on;

    logic [WIDTH_W-1:0]  cur_width;
    logic [HEIGHT_W-1:0] cur_height;
    logic [LEN_W-1:0]    cur_length;

    framed_bitmap_receiver_crc32 u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    frb_stream_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("framed_bitmap_receiver_crc32: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result sink pacing: short random stalls, plus one long hold on request
    initial begin : sink_pacing
        m_tready = 1'b0;
        hold_done = 0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_req != hold_done) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_done = hold_req;
                m_tready <= 1'b1;
            end else if (gaps_on && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // called and returns at a falling edge
    task automatic push_item(input logic kind, input logic [7:0] b);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
        case (idx)
            REG_WIDTH:  cur_width = v[WIDTH_W-1:0];
            REG_HEIGHT: cur_height = v[HEIGHT_W-1:0];
            REG_LENGTH: cur_length = v[LEN_W-1:0];
            default: ;
        endcase
    endtask

    // a frame byte, preceded by a refused page change where one is planned
    task automatic frame_byte(input logic [7:0] b);
        if (frame_pos == refuse_at)
            push_item(KIND_PAGE, 8'($urandom));
        frame_pos++;
        push_item(KIND_BYTE, b);
    endtask

    task automatic send_magic();
        push_item(KIND_BYTE, MAGIC_0);
        push_item(KIND_BYTE, MAGIC_1);
        push_item(KIND_BYTE, MAGIC_2);
        push_item(KIND_BYTE, MAGIC_3);
        frame_pos = 0;
    endtask

    function automatic logic [63:0] header_now();
        return {12'd0, cur_length, cur_height, cur_width};
    endfunction

    task automatic send_header(input logic [63:0] hdr);
        for (int k = 0; k < 8; k++)
            frame_byte(hdr[8*k +: 8]);
    endtask

    task automatic send_payload(input int n, inout logic [31:0] crc);
        logic [7:0] b;
        repeat (n) begin
            b = 8'($urandom);
            crc = crc32_fold(crc, b);
            frame_byte(b);
        end
    endtask

    task automatic send_trailer(input logic [31:0] crc);
        logic [31:0] fcs;
        fcs = crc ^ CRC_ONES;
        for (int k = 0; k < 4; k++)
            frame_byte(fcs[8*k +: 8]);
    endtask

    task automatic send_frame(input frame_fault_e fault);
        logic [63:0] hdr;
        logic [31:0] crc;
        int n;
        n = cur_length;
        hdr = header_now();
        refuse_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, n + 11) : -1;
        if ($urandom_range(0, 3) == 0)
            push_item(KIND_PAGE, 8'($urandom));
        send_magic();
        if (fault == FRAME_BAD_HEADER) begin
            send_header(hdr ^ (64'd1 << $urandom_range(0, 63)));
        end else begin
            send_header(hdr);
            crc = CRC_ONES;
            send_payload(n, crc);
            if (fault == FRAME_BAD_CRC)
                crc = crc ^ (32'd1 << $urandom_range(0, 31));
            send_trailer(crc);
        end
        refuse_at = -1;
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 8);
        repeat (n) begin
            case ($urandom_range(0, 5))
                0: push_item(KIND_PAGE, 8'($urandom));
                1: push_item(KIND_BYTE, MAGIC_0);
                2: push_item(KIND_BYTE, MAGIC_1);
                default: push_item(KIND_BYTE, 8'($urandom));
            endcase
        end
    endtask

    task automatic pick_config();
        logic [CFG_DATA_W-1:0] v;
        case ($urandom_range(0, 3))
            0: v = 20'd1;
            1: v = 20'h0FFFF;
            default: v = 20'($urandom);
        endcase
        write_reg(REG_WIDTH, v);
        case ($urandom_range(0, 3))
            0: v = 20'd1;
            1: v = 20'h0FFFF;
            default: v = 20'($urandom);
        endcase
        write_reg(REG_HEIGHT, v);
        case ($urandom_range(0, 9))
            0: v = 20'd0;
            1: v = 20'($urandom_range(13, 48));
            default: v = 20'($urandom_range(1, 12));
        endcase
        write_reg(REG_LENGTH, v);
        case ($urandom_range(0, 5))
            0: v = 20'd0;
            1: v = 20'd255;
            default: v = 20'($urandom_range(1, 4));
        endcase
        write_reg(REG_LIMIT, v);
        if ($urandom_range(0, 7) == 0)
            write_reg(REG_SPARE + 8'($urandom_range(0, 251)), 20'($urandom));
    endtask

    initial begin : stimulus
        logic [31:0] crc;
        bit first_phase;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'd0;
        s_tuser = KIND_BYTE;
        cfg_valid = 1'b0;
        cfg_index = REG_WIDTH;
        cfg_data = '0;
        items_sent = 0;
        hold_req = 0;
        frame_pos = 0;
        refuse_at = -1;
        gaps_on = 1'b1;
        first_phase = 1'b1;
        cur_width = RST_WIDTH;
        cur_height = RST_HEIGHT;
        cur_length = RST_LENGTH;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part
        write_reg(REG_WIDTH, 20'hF0001);
        write_reg(REG_HEIGHT, 20'h0FFFF);
        write_reg(REG_LENGTH, 20'd1);
        write_reg(REG_LIMIT, 20'd0);
        write_reg(REG_SPARE, 20'hFFFFF);
        write_reg(REG_LAST, 20'h5A5A5);
        push_item(KIND_PAGE, 8'hFF);
        push_item(KIND_BYTE, MAGIC_0);
        send_magic();
        refuse_at = 2;
        send_header(header_now());
        crc = CRC_ONES;
        send_payload(1, crc);
        send_trailer(crc);
        refuse_at = -1;
        push_item(KIND_BYTE, MAGIC_0);
        push_item(KIND_BYTE, MAGIC_1);
        push_item(KIND_BYTE, 8'h00);
        send_magic();
        send_header(header_now() ^ (64'd1 << 63));
        send_magic();
        send_header(header_now());
        crc = CRC_ONES;
        send_payload(1, crc);
        send_trailer(~crc);
        settle();

        // empty payload; crc reject must keep the page-change flag
        write_reg(REG_LENGTH, 20'd0);
        write_reg(REG_LIMIT, 20'd255);
        send_magic();
        send_header(header_now());
        send_trailer(CRC_ONES);
        push_item(KIND_PAGE, 8'h00);
        send_magic();
        send_header(header_now());
        send_trailer(32'd0);
        send_magic();
        send_header(header_now());
        send_trailer(CRC_ONES);
        settle();

        // length shortened while the payload is running
        write_reg(REG_WIDTH, 20'h0FFFF);
        write_reg(REG_HEIGHT, 20'd1);
        write_reg(REG_LENGTH, 20'hFFFFF);
        send_magic();
        send_header(header_now());
        crc = CRC_ONES;
        send_payload(3, crc);
        settle();
        write_reg(REG_LENGTH, 20'd2);
        send_payload(1, crc);
        send_trailer(crc);

        // random part
        while (items_sent < ITEM_TARGET) begin
            settle();
            pick_config();
            gaps_on = (items_sent < ITEM_TARGET - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
            if (first_phase) begin
                gaps_on = 1'b1;
                hold_req = hold_req + 1;
                first_phase = 1'b0;
            end
            repeat ($urandom_range(4, 10)) begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: send_frame(FRAME_GOOD);
                    12, 13, 14: send_frame(FRAME_BAD_CRC);
                    15, 16: send_frame(FRAME_BAD_HEADER);
                    default: send_noise();
                endcase
            end
        end

        settle();
        repeat (4) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("framed_bitmap_receiver_crc32: match");
        else
            $display("framed_bitmap_receiver_crc32: mismatch");
        $finish;
    end

endmodule
